// File: design/rbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_pkg: shared types and constants of the ring buffer FIFO
// Widths, operation codes and the command that runs from front to back.
// ----------------------------------------------------------------------------
package rbf_pkg;

    localparam int MAX_DEPTH   = 256;
    localparam int ADDR_W      = $clog2(MAX_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int MAX_BURST   = 16;
    localparam int REQ_W       = 5;
    localparam int IDX_W       = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
    localparam int LG_W        = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        K_PUSH   = 2'd0,
        K_BURST  = 2'd1,
        K_STATUS = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;     // write address, or first read address
        logic [ADDR_W-1:0]   mask;     // capacity - 1
        logic [REQ_W-1:0]    count;    // elements in a burst, 1..MAX_BURST
        logic [DATA_W-1:0]   data;
        logic                accepted;
        logic [CNT_W-1:0]    fill;     // fill level after the item
        logic                empty;
        logic                full;
    } t_cmd;

endpackage

// File: design/rbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_front: item intake and bookkeeping
// Holds the counts and capacity, sizes each item and queues a command.
// ----------------------------------------------------------------------------
module rbf_front import rbf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LG_W-1:0]    i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [DATA_W-1:0]  i_push_data,
    input  logic [REQ_W-1:0]   i_req,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output t_cmd               o_cmd
);

    logic [LG_W-1:0]  r_lg;
    logic [CNT_W-1:0] r_wc, n_wc;
    logic [CNT_W-1:0] r_rc, n_rc;

    logic [LG_W-1:0]   lg_eff;
    logic [CNT_W-1:0]  cap;
    logic [ADDR_W-1:0] mask;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  fill_after;
    logic [REQ_W-1:0]  req_c;
    logic [REQ_W-1:0]  n_elem;
    logic              push_ok;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;

    always_comb begin
        lg_eff = (r_lg == '0) ? LG_W'(1) : r_lg;
        if (lg_eff >= LG_W'(ADDR_W)) begin
            cap = CNT_W'(MAX_DEPTH);
        end else begin
            cap = CNT_W'(1) << lg_eff;
        end
        mask  = ADDR_W'(cap - CNT_W'(1));
        fill  = r_wc - r_rc;
        req_c = (i_req > REQ_W'(MAX_BURST)) ? REQ_W'(MAX_BURST) : i_req;
        n_elem = (CNT_W'(req_c) < fill) ? req_c : REQ_W'(fill);
        push_ok = fill < cap;

        n_wc = r_wc;
        n_rc = r_rc;
        o_cmd.kind     = K_STATUS;
        o_cmd.addr     = r_rc[ADDR_W-1:0] & mask;
        o_cmd.mask     = mask;
        o_cmd.count    = n_elem;
        o_cmd.data     = i_push_data;
        o_cmd.accepted = 1'b0;

        case (t_op'(i_op))
            OP_PUSH: begin
                o_cmd.kind     = K_PUSH;
                o_cmd.addr     = r_wc[ADDR_W-1:0] & mask;
                o_cmd.accepted = push_ok;
                if (push_ok) begin
                    n_wc = r_wc + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (n_elem != '0) begin
                    o_cmd.kind = K_BURST;
                    n_rc = r_rc + CNT_W'(n_elem);
                end
            end
            OP_PEEK: begin
                if (n_elem != '0) begin
                    o_cmd.kind = K_BURST;
                end
            end
            default: begin
                o_cmd.kind = K_STATUS;
            end
        endcase

        fill_after  = n_wc - n_rc;
        o_cmd.fill  = fill_after;
        o_cmd.empty = (fill_after == '0);
        o_cmd.full  = (fill_after == cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg <= LG_W'(ADDR_W);
            r_wc <= '0;
            r_rc <= '0;
        end else if (i_cfg_valid) begin
            // a new capacity empties the buffer
            r_lg <= i_cfg_data;
            r_wc <= '0;
            r_rc <= '0;
        end else if (accept) begin
            r_wc <= n_wc;
            r_rc <= n_rc;
        end
    end

endmodule

// File: design/rbf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_queue: command queue between front and back
// Small register queue so that each side may stall on its own.
// ----------------------------------------------------------------------------
module rbf_queue import rbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/rbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbf_back: element store and result sequencer
// Runs queued commands in order: writes pushes, reads bursts one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rbf_back import rbf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_read_data,
    output logic                o_data_valid,
    output logic                o_last,
    output logic                o_accepted,
    output logic [CNT_W-1:0]    o_fill,
    output logic                o_empty,
    output logic                o_full
);

    logic [DATA_W-1:0] r_store [MAX_DEPTH];
    logic [DATA_W-1:0] r_mem_q;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic              r_out_dv;
    logic              r_out_last;
    logic              r_out_acc;
    logic [CNT_W-1:0]  r_out_fill;
    logic              r_out_empty;
    logic              r_out_full;

    logic              load;
    logic              is_burst;
    logic              burst_last;
    logic [ADDR_W-1:0] rd_addr;

    assign load       = i_cmd_valid && (!r_out_valid || i_ready);
    assign is_burst   = (i_cmd.kind == K_BURST);
    assign burst_last = ((REQ_W'(r_idx) + REQ_W'(1)) == i_cmd.count);
    assign rd_addr    = (i_cmd.addr + ADDR_W'(r_idx)) & i_cmd.mask;
    assign o_cmd_pop  = load && (!is_burst || burst_last);

    // store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (load && (i_cmd.kind == K_PUSH) && i_cmd.accepted) begin
            r_store[i_cmd.addr] <= i_cmd.data;
        end
        if (load && is_burst) begin
            r_mem_q <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_dv    <= is_burst;
            r_out_last  <= !is_burst || burst_last;
            r_out_acc   <= i_cmd.accepted;
            r_out_fill  <= i_cmd.fill;
            r_out_empty <= i_cmd.empty;
            r_out_full  <= i_cmd.full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load && is_burst) begin
                r_idx <= burst_last ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_out_dv ? r_mem_q : '0;
    assign o_data_valid = r_out_dv;
    assign o_last       = r_out_last;
    assign o_accepted   = r_out_acc;
    assign o_fill       = r_out_fill;
    assign o_empty      = r_out_empty;
    assign o_full       = r_out_full;

    // a burst in progress keeps its command at the queue head
    a_idx_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (i_cmd_valid && is_burst))
        else $error("burst index set without a burst at the head");

    a_nodata_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_dv) |-> r_out_last)
        else $error("status result not marked last");

    a_data_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dv) |-> !r_out_acc)
        else $error("element result flagged as push stored");

    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && is_burst && burst_last) |=> (r_idx == '0))
        else $error("burst index not cleared after last element");

endmodule

// File: design/ring_buffer_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_fifo: power-of-two ring buffer FIFO with burst reads
// Push, pop-burst and peek-burst items in; one status/element item per result.
// ----------------------------------------------------------------------------
// Each input item is accepted into a four-entry command queue; the back
// end then produces one result for a push or a status item, and one per
// delivered element for a pop or peek, so a burst of n elements holds the
// back end for its whole length while the front keeps taking items until
// the queue is full. The element store is read through a registered port,
// which sets the one element per cycle burst rate while the output is not
// stalled. Writing the capacity register (log2, 1..8) empties the FIFO;
// write it only while idle. There is no clearing pass after reset.
module ring_buffer_fifo import rbf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,       // capacity_log2
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // push_data[31:0], request_count[36:32], zero
    input  logic [1:0]  i_s_axis_tuser,   // operation[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // read_data[31:0], push_accepted[32],
                                          // fill_level[41:33], is_empty[42],
                                          // is_full[43], zero
    output logic        o_m_axis_tuser,   // data_valid
    output logic        o_m_axis_tlast    // last_result
);

    t_cmd              front_cmd;
    t_cmd              head_cmd;
    logic              front_valid;
    logic              q_ready;
    logic              q_valid;
    logic              q_pop;
    logic [DATA_W-1:0] read_data;
    logic              accepted;
    logic [CNT_W-1:0]  fill;
    logic              empty;
    logic              full;

    rbf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_push_data (i_s_axis_tdata[DATA_W-1:0]),
        .i_req       (i_s_axis_tdata[DATA_W+REQ_W-1:DATA_W]),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_ready),
        .o_cmd       (front_cmd)
    );

    rbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (q_ready),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    rbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (head_cmd),
        .o_cmd_pop    (q_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_read_data  (read_data),
        .o_data_valid (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast),
        .o_accepted   (accepted),
        .o_fill       (fill),
        .o_empty      (empty),
        .o_full       (full)
    );

    assign o_m_axis_tdata = {4'b0000, full, empty, fill, accepted, read_data};

endmodule
